// ===== rtl/core/clnib_pkg.sv =====
// Shared types, constants and lookup functions for the character LCD nibble interface.
package clnib_pkg;

	typedef enum logic [2:0] {
		KIND_CMD   = 3'd0,
		KIND_DATA  = 3'd1,
		KIND_CURS  = 3'd2,
		KIND_INIT  = 3'd3,
		KIND_CLEAR = 3'd4
	} kind_t;

	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WAIT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_WAIT  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POWER_WAIT = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_WAIT = 8'd3;

	localparam logic [7:0] RST_SHORT_WAIT = 8'd1;
	localparam logic [7:0] RST_LONG_WAIT  = 8'd3;
	localparam logic [7:0] RST_POWER_WAIT = 8'd40;
	localparam logic [7:0] RST_CLEAR_WAIT = 8'd3;

	localparam logic [7:0] CMD_CLEAR = 8'h01;

	// step counter: up to 21 steps per request
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] LAST_BYTE  = 5'd3;
	localparam logic [STEP_W-1:0] LAST_CLEAR = 5'd4;
	localparam logic [STEP_W-1:0] LAST_INIT  = 5'd20;

	// DDRAM base address of each display row
	function automatic logic [7:0] row_base(input logic [1:0] r);
		logic [7:0] b;
		case (r)
			2'd0:    b = 8'h80;
			2'd1:    b = 8'hC0;
			2'd2:    b = 8'h94;
			default: b = 8'hD4;
		endcase
		return b;
	endfunction

	// power-up command sequence
	function automatic logic [7:0] init_cmd(input logic [2:0] i);
		logic [7:0] c;
		case (i)
			3'd0:    c = 8'h02;
			3'd1:    c = 8'h28;
			3'd2:    c = 8'h01;
			3'd3:    c = 8'h0C;
			3'd4:    c = 8'h06;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/char_lcd_nibble_interface.sv =====
// Character LCD 4-bit bus sequencer: expands requests into pin steps.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------------------
//  request  | in        | in_valid / in_stall | kind, data_byte, row, column
//  pin step | out       | out_valid/out_stall | data_nibble, reg_select, strobe_res,
//           |           |                     | wait_ms, last
//  config   | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One pin step leaves per cycle while out_stall is low: a byte request has 4 steps, a clear 5,
// an init 21, set by the step counter of the request register. Cursor requests for rows 4..7 and
// unknown kinds produce nothing.
// The next request is taken in the cycle its predecessor's last step moves into the
// output register, so requests follow each other with no gap.
// Reset clears valids, counters and restores the four wait registers to their defaults.
// out_stall holds the output register; the request register then stalls behind it.
module char_lcd_nibble_interface (
	input  logic                           clk,
	input  logic                           arst_n,
	// request
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [2:0]                     kind,
	input  logic [7:0]                     data_byte,
	input  logic [2:0]                     row,
	input  logic [7:0]                     column,
	// pin steps
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [3:0]                     data_nibble,
	output logic                           reg_select,
	output logic                           strobe_res,
	output logic [7:0]                     wait_ms,
	output logic                           last,
	// configuration
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [clnib_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data
);
	import clnib_pkg::*;

	// configuration registers
	logic [7:0] short_wait_q, long_wait_q, power_wait_q, clear_wait_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_wait_q <= RST_SHORT_WAIT;
			long_wait_q  <= RST_LONG_WAIT;
			power_wait_q <= RST_POWER_WAIT;
			clear_wait_q <= RST_CLEAR_WAIT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SHORT_WAIT: short_wait_q <= cfg_data;
				CFG_LONG_WAIT:  long_wait_q  <= cfg_data;
				CFG_POWER_WAIT: power_wait_q <= cfg_data;
				CFG_CLEAR_WAIT: clear_wait_q <= cfg_data;
				default: ;	// unmapped index: dropped
			endcase
		end
	end

	// request register (stage 1): resolved byte plus step counter
	logic              valid_s1;
	kind_t             kind_s1;
	logic [7:0]        byte_s1;
	logic              rs_s1;
	logic [STEP_W-1:0] cnt_s1;
	logic [STEP_W-1:0] lastidx_s1;

	// incoming request decode
	kind_t             in_kind;
	logic              in_has_steps;
	logic [7:0]        in_byte;
	logic              in_rs;
	logic [STEP_W-1:0] in_lastidx;

	always_comb begin
		in_kind      = kind_t'(kind);
		in_has_steps = 1'b0;
		in_byte      = data_byte;
		in_rs        = 1'b0;
		in_lastidx   = LAST_BYTE;
		case (in_kind)
			KIND_CMD: begin
				in_has_steps = 1'b1;
			end
			KIND_DATA: begin
				in_has_steps = 1'b1;
				in_rs        = 1'b1;
			end
			KIND_CURS: begin
				in_has_steps = !row[2];
				in_byte      = row_base(row[1:0]) + column;	// wraps at 256
			end
			KIND_INIT: begin
				in_has_steps = 1'b1;
				in_lastidx   = LAST_INIT;
			end
			KIND_CLEAR: begin
				in_has_steps = 1'b1;
				in_byte      = CMD_CLEAR;
				in_lastidx   = LAST_CLEAR;
			end
			default: in_has_steps = 1'b0;
		endcase
	end

	// current step of the request in stage 1
	logic              step_last;
	logic [STEP_W-1:0] idx;
	logic [1:0]        phase;
	logic [7:0]        cur_byte;
	logic [3:0]        step_nib;
	logic              step_rs;
	logic              step_en;
	logic [7:0]        step_wait;

	always_comb begin
		step_last = (cnt_s1 == lastidx_s1);
		// init has a leading power-on wait before its bytes
		idx       = (kind_s1 == KIND_INIT) ? cnt_s1 - 1'b1 : cnt_s1;
		phase     = idx[1:0];
		cur_byte  = (kind_s1 == KIND_INIT) ? init_cmd(idx[4:2]) : byte_s1;
		step_nib  = phase[1] ? cur_byte[3:0] : cur_byte[7:4];
		step_rs   = rs_s1;
		step_en   = !phase[0];
		case (phase)
			2'd1:    step_wait = short_wait_q;
			2'd3:    step_wait = long_wait_q;
			default: step_wait = 8'd0;
		endcase
		if (kind_s1 == KIND_INIT && cnt_s1 == '0) begin
			step_nib  = 4'h0;
			step_rs   = 1'b0;
			step_en   = 1'b0;
			step_wait = power_wait_q;
		end
		if (kind_s1 == KIND_CLEAR && cnt_s1 == LAST_CLEAR) begin
			// hold the pins after the clear command
			step_nib  = 4'h1;
			step_rs   = 1'b0;
			step_en   = 1'b0;
			step_wait = clear_wait_q;
		end
	end

	logic out_load;
	logic advance;
	logic in_take;

	assign out_load = !out_valid || !out_stall;
	assign advance  = valid_s1 && out_load;
	assign in_stall = valid_s1 && !(advance && step_last);
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_s1   <= '0;
		end else if (in_take) begin
			valid_s1 <= in_has_steps;
			cnt_s1   <= '0;
		end else if (advance) begin
			valid_s1 <= !step_last;
			cnt_s1   <= cnt_s1 + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_s1    <= in_kind;
			byte_s1    <= in_byte;
			rs_s1      <= in_rs;
			lastidx_s1 <= in_lastidx;
		end
	end

	// output register (stage 2)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_nibble <= step_nib;
			reg_select  <= step_rs;
			strobe_res  <= step_en;
			wait_ms     <= step_wait;
			last        <= step_last;
		end
	end

	// counter never runs past the request's final step
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> cnt_s1 <= lastidx_s1)
		else $error("step counter past final step");

	// enable-high steps never carry a wait
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && strobe_res |-> wait_ms == 8'd0)
		else $error("wait on enable-high step");

	// final step moving out with nothing new taken empties stage 1
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && step_last && !in_take |=> !valid_s1)
		else $error("request register not released after final step");

	// a step leaves stage 1 only into a free or draining output register
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid && out_stall |=> valid_s1 && $stable(cnt_s1))
		else $error("step lost under output stall");

endmodule

// ===== bench/clnib_step_checker.sv =====
// Pin-step predictor and scoreboard for the character LCD nibble interface.
module clnib_step_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [2:0]                      kind,
	input  logic [7:0]                      data_byte,
	input  logic [2:0]                      row,
	input  logic [7:0]                      column,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [3:0]                      data_nibble,
	input  logic                            reg_select,
	input  logic                            strobe_res,
	input  logic [7:0]                      wait_ms,
	input  logic                            last,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [clnib_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                      cfg_data,
	output int                              mismatch_count,
	output int                              steps_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import clnib_pkg::*;

	typedef struct packed {
		logic [3:0] nibble;
		logic       rs;
		logic       en;
		logic [7:0] hold_ms;
		logic       fin;
	} pin_step_t;

	pin_step_t  expected_steps[$];
	logic [7:0] short_ms, long_ms, power_ms, clear_ms;

	function automatic logic [7:0] cursor_addr(input logic [2:0] r, input logic [7:0] c);
		logic [7:0] base;
		case (r[1:0])
			2'd0:    base = 8'h80;
			2'd1:    base = 8'hC0;
			2'd2:    base = 8'h94;
			default: base = 8'hD4;
		endcase
		return base + c;
	endfunction

	function automatic logic [7:0] power_up_byte(input int i);
		logic [7:0] b;
		case (i)
			0:       b = 8'h02;
			1:       b = 8'h28;
			2:       b = 8'h01;
			3:       b = 8'h0C;
			default: b = 8'h06;
		endcase
		return b;
	endfunction

	function automatic void queue_step(input logic [3:0] nib, input logic rs, input logic en,
			input logic [7:0] hold);
		pin_step_t s;
		s = {nib, rs, en, hold, 1'b0};
		expected_steps.push_back(s);
	endfunction

	// high nibble strobe, short hold, low nibble strobe, long hold
	function automatic void queue_byte(input logic [7:0] b, input logic rs);
		queue_step(b[7:4], rs, 1'b1, 8'h00);
		queue_step(b[7:4], rs, 1'b0, short_ms);
		queue_step(b[3:0], rs, 1'b1, 8'h00);
		queue_step(b[3:0], rs, 1'b0, long_ms);
	endfunction

	function automatic void predict_request(input logic [2:0] k, input logic [7:0] b,
			input logic [2:0] r, input logic [7:0] c);
		int first;
		first = expected_steps.size();
		case (k)
			KIND_CMD:   queue_byte(b, 1'b0);
			KIND_DATA:  queue_byte(b, 1'b1);
			KIND_CURS:  if (r < 3'd4) queue_byte(cursor_addr(r, c), 1'b0);
			KIND_INIT: begin
				queue_step(4'h0, 1'b0, 1'b0, power_ms);
				for (int i = 0; i < 5; i++)
					queue_byte(power_up_byte(i), 1'b0);
			end
			KIND_CLEAR: begin
				queue_byte(CMD_CLEAR, 1'b0);
				queue_step(CMD_CLEAR[3:0], 1'b0, 1'b0, clear_ms);
			end
			default: ;
		endcase
		if (expected_steps.size() > first)
			expected_steps[expected_steps.size() - 1].fin = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pin_step_t want, got;
		if (!arst_n) begin
			short_ms = RST_SHORT_WAIT;
			long_ms  = RST_LONG_WAIT;
			power_ms = RST_POWER_WAIT;
			clear_ms = RST_CLEAR_WAIT;
			expected_steps.delete();
			mismatch_count = 0;
			steps_pending  = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SHORT_WAIT: short_ms = cfg_data;
					CFG_LONG_WAIT:  long_ms  = cfg_data;
					CFG_POWER_WAIT: power_ms = cfg_data;
					CFG_CLEAR_WAIT: clear_ms = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				got = {data_nibble, reg_select, strobe_res, wait_ms, last};
				if (expected_steps.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected step nib=%h rs=%b en=%b wait=%0d last=%b",
							$time, got.nibble, got.rs, got.en, got.hold_ms, got.fin);
				end else begin
					want = expected_steps.pop_front();
					if (got.nibble !== want.nibble || got.rs !== want.rs || got.en !== want.en ||
							got.hold_ms !== want.hold_ms || got.fin !== want.fin) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"%0t: step error exp nib=%h rs=%b en=%b wait=%0d last=%b",
								" got nib=%h rs=%b en=%b wait=%0d last=%b"}, $time,
								want.nibble, want.rs, want.en, want.hold_ms, want.fin,
								got.nibble, got.rs, got.en, got.hold_ms, got.fin);
					end
				end
			end
			if (in_valid && !in_stall)
				predict_request(kind, data_byte, row, column);
			steps_pending = expected_steps.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top: request, back-pressure and register stimulus for the LCD nibble sequencer.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import clnib_pkg::*;

	// run limit with margin over the slowest legal run (every request an init, long stalls)
	localparam int LIMIT_CYCLES = 1_500_000;
	// idle cycles allowed after the last step, covers requests that emit nothing
	localparam int SETTLE_CYCLES = 8;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [2:0]           kind = KIND_CMD;
	logic [7:0]           data_byte = 8'h00;
	logic [2:0]           row = 3'd0;
	logic [7:0]           column = 8'h00;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [3:0]           data_nibble;
	logic                 reg_select;
	logic                 strobe_res;
	logic [7:0]           wait_ms;
	logic                 last;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_SHORT_WAIT;
	logic [7:0]           cfg_data = 8'h00;

	int mismatch_count;
	int steps_pending;

	// knobs: gaps between requests and output back-pressure
	bit idle_on  = 1'b1;
	bit stall_on = 1'b1;

	always #5 clk = ~clk;

	char_lcd_nibble_interface u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.data_byte  (data_byte),
		.row        (row),
		.column     (column),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.data_nibble(data_nibble),
		.reg_select (reg_select),
		.strobe_res (strobe_res),
		.wait_ms    (wait_ms),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	clnib_step_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.data_byte     (data_byte),
		.row           (row),
		.column        (column),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.data_nibble   (data_nibble),
		.reg_select    (reg_select),
		.strobe_res    (strobe_res),
		.wait_ms       (wait_ms),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatch_count(mismatch_count),
		.steps_pending (steps_pending)
	);

	// mostly back-to-back, some short gaps, rare long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// One request transfer. Payload is driven at the falling edge and held until the
	// rising edge that sees in_stall low. A zero gap keeps in_valid high so the next
	// request follows straight on.
	task automatic send_req(input logic [2:0] k, input logic [7:0] b, input logic [2:0] r,
			input logic [7:0] c);
		int gap;
		@(negedge clk);
		kind      <= k;
		data_byte <= b;
		row       <= r;
		column    <= c;
		in_valid  <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		gap = idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Sender holds off until every predicted step has come out, then lets the block
	// finish any request that emits nothing.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (steps_pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Registers change only with the block idle. Each setting also writes an index
	// past the last register, which must leave all four untouched.
	task automatic set_waits(input logic [7:0] s, input logic [7:0] l, input logic [7:0] p,
			input logic [7:0] c);
		drain();
		cfg_write(CFG_SHORT_WAIT, s);
		cfg_write(CFG_LONG_WAIT, l);
		cfg_write(CFG_POWER_WAIT, p);
		cfg_write(CFG_CLEAR_WAIT, c);
		cfg_write(CFG_IDX_W'($urandom_range(CFG_CLEAR_WAIT + 1, 255)),
			8'($urandom_range(0, 255)));
	endtask

	// Random request mix. Rows above three and unknown kinds emit nothing and
	// do not count toward the phase length.
	task automatic send_random(output bit emits);
		logic [2:0] k;
		logic [2:0] r;
		logic [7:0] b;
		logic [7:0] c;
		int pick;
		b     = 8'($urandom_range(0, 255));
		c     = 8'($urandom_range(0, 255));
		r     = 3'($urandom_range(0, 3));
		pick  = $urandom_range(0, 99);
		emits = 1'b1;
		if (pick < 40)
			k = KIND_DATA;
		else if (pick < 60)
			k = KIND_CMD;
		else if (pick < 78)
			k = KIND_CURS;
		else if (pick < 83)
			k = KIND_INIT;
		else if (pick < 90)
			k = KIND_CLEAR;
		else if (pick < 95) begin
			k     = KIND_CURS;
			r     = 3'($urandom_range(4, 7));
			emits = 1'b0;
		end else begin
			k     = 3'($urandom_range(KIND_CLEAR + 1, 7));
			emits = 1'b0;
		end
		send_req(k, b, r, c);
	endtask

	// A phase: random requests mixed with screen updates (cursor placement followed
	// by a short printable string), plus the odd full stop of the sender.
	task automatic run_phase(input int n);
		int made;
		int len;
		bit emits;
		made = 0;
		while (made < n) begin
			if ($urandom_range(0, 99) < 15) begin
				send_req(KIND_CURS, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 3)),
					8'($urandom_range(0, 39)));
				made++;
				len = $urandom_range(3, 8);
				repeat (len) begin
					send_req(KIND_DATA, 8'($urandom_range(8'h20, 8'h7E)),
						3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
					made++;
				end
			end else begin
				send_random(emits);
				if (emits)
					made++;
			end
			if ($urandom_range(0, 99) == 0)
				drain();
		end
	endtask

	// Output back-pressure: ready runs and stall bursts of random length.
	initial begin : sink_pressure
		int run;
		forever begin
			run = pick_gap() + 1;
			repeat (run) @(negedge clk) out_stall <= 1'b0;
			if (stall_on) begin
				run = pick_gap();
				repeat (run) @(negedge clk) out_stall <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset wait values, field extremes, every kind
		send_req(KIND_CMD,  8'h00, 3'd0, 8'h00);
		send_req(KIND_CMD,  8'hFF, 3'd7, 8'hFF);
		send_req(KIND_DATA, 8'h00, 3'd0, 8'h00);
		send_req(KIND_DATA, 8'hFF, 3'd7, 8'hFF);
		send_req(KIND_DATA, 8'hA5, 3'd2, 8'h5A);
		send_req(KIND_CURS, 8'h00, 3'd0, 8'h00);
		send_req(KIND_CURS, 8'hFF, 3'd1, 8'hFF);
		send_req(KIND_CURS, 8'h00, 3'd2, 8'h6B);
		// row three base plus column wraps past 0xFF
		send_req(KIND_CURS, 8'h00, 3'd3, 8'h2C);
		send_req(KIND_CURS, 8'h00, 3'd3, 8'hFF);
		// rows above three emit nothing
		send_req(KIND_CURS, 8'h00, 3'd4, 8'h00);
		send_req(KIND_CURS, 8'hFF, 3'd7, 8'hFF);
		send_req(KIND_INIT, 8'h00, 3'd0, 8'h00);
		send_req(KIND_CLEAR, 8'hFF, 3'd7, 8'hFF);
		// unknown kinds emit nothing
		send_req(3'(KIND_CLEAR + 1), 8'h00, 3'd0, 8'h00);
		send_req(3'(KIND_CLEAR + 2), 8'hFF, 3'd5, 8'hFF);
		send_req(3'd7, 8'h3C, 3'd6, 8'hC3);
		send_req(KIND_DATA, 8'h41, 3'd0, 8'h00);

		// all waits at the low extreme
		set_waits(8'h00, 8'h00, 8'h00, 8'h00);
		send_req(KIND_INIT, 8'h00, 3'd0, 8'h00);
		send_req(KIND_CLEAR, 8'h00, 3'd0, 8'h00);
		run_phase(90);

		// all waits at the high extreme
		set_waits(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_req(KIND_INIT, 8'h00, 3'd0, 8'h00);
		send_req(KIND_CLEAR, 8'h00, 3'd0, 8'h00);
		run_phase(90);

		// random waits; first a stretch with no gaps and no stalls at all
		set_waits(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		idle_on  = 1'b0;
		stall_on = 1'b0;
		run_phase(60);
		idle_on  = 1'b1;
		stall_on = 1'b1;
		run_phase(40);

		set_waits(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		run_phase(90);

		drain();
		repeat (20) @(negedge clk);
		if (mismatch_count == 0 && steps_pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
